// ===== hdl/iogj_pkg.sv =====
package iogj_pkg;

   localparam int GroupDepth = 64;
   localparam int IdxW = $clog2(GroupDepth);
   localparam int CntW = $clog2(GroupDepth + 1);
   localparam int QueueDepth = 2;

   localparam logic [0:0] RegSplitLow = 1'b0;
   localparam logic [0:0] RegSplitHigh = 1'b1;

   localparam logic [31:0] SplitLowReset = 32'd431819885;
   localparam logic [31:0] SplitHighReset = 32'd994578439;

   typedef struct packed {
      logic        source;
      logic [31:0] group_key;
      logic [31:0] query_id;
      logic [15:0] query_size;
      logic [15:0] span_start;
      logic [15:0] span_end;
   } req_type;

   typedef struct packed {
      logic [31:0] low_query;
      logic [31:0] high_query;
      logic [15:0] pair_norm;
      logic [1:0]  bucket;
      logic        last;
      logic        overflowed;
   } rsp_type;

   typedef struct packed {
      logic [31:0] query_id;
      logic [15:0] query_size;
      logic [15:0] span_start;
      logic [15:0] span_end;
   } entry_type;

   // classified record handed from front to back
   typedef struct packed {
      logic        source;
      logic        new_key;
      entry_type   rec;
   } job_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_STORE
   } bk_state_type;

endpackage

// ===== hdl/iogj_front.sv =====
module iogj_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_start,
   output logic                req_busy,
   input  iogj_pkg::req_type   req_data,
   output logic                job_valid,
   output iogj_pkg::job_type   job_data,
   input  logic                job_take
);
   import iogj_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);

   logic [31:0]    key_ff, key_in;
   logic           key_valid_ff, key_valid_in;
   job_type        q_ff [QueueDepth];
   logic [PtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]  cnt_ff, cnt_in;
   logic           push;
   job_type        job;

   assign req_busy = (cnt_ff == PtrW'(0) + (PtrW+1)'(QueueDepth));
   assign push = req_start && !req_busy;

   always_comb begin
      job.source = req_data.source;
      job.new_key = !key_valid_ff || (req_data.group_key != key_ff);
      job.rec.query_id = req_data.query_id;
      job.rec.query_size = req_data.query_size;
      job.rec.span_start = req_data.span_start;
      job.rec.span_end = req_data.span_end;
   end

   always_comb begin
      key_in = key_ff;
      key_valid_in = key_valid_ff;
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         key_in = req_data.group_key;
         key_valid_in = 1'b1;
         wr_in = (wr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (job_take) begin
         rd_in = (rd_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ff + 1'b1;
      end
      cnt_in = cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(job_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         key_valid_ff <= 1'b0;
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         key_ff <= key_in;
         key_valid_ff <= key_valid_in;
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= job;
      end
   end

   assign job_valid = (cnt_ff != '0);
   assign job_data = q_ff[rd_ff];

endmodule

// ===== hdl/iogj_back.sv =====
module iogj_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   input  iogj_pkg::job_type   job_data,
   output logic                job_take,
   input  logic [31:0]         split_low,
   input  logic [31:0]         split_high,
   output logic                rsp_strobe,
   output iogj_pkg::rsp_type   rsp_data
);
   import iogj_pkg::*;

   bk_state_type   state_ff, state_in;
   job_type        cur_ff, cur_in;
   logic [CntW-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic           ovf_ff, ovf_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic [CntW-1:0] limit;
   entry_type      mem_a [GroupDepth];
   entry_type      mem_b [GroupDepth];
   entry_type      rd_a_ff, rd_b_ff;
   logic [IdxW-1:0] rd_addr;
   logic           rd_ok_ff, rd_ok_in;
   logic           pend_ff, pend_in;
   rsp_type        hold_ff, hold_in;
   logic           wr_en;
   logic [CntW-1:0] own_cnt;
   entry_type      s;
   logic signed [17:0] hi, lo, inter, uhi, ulo, uni;
   logic signed [20:0] lhs;
   logic           passes;
   logic [31:0]    lq;

   assign limit = cur_ff.source ? cnt_a_ff : cnt_b_ff;
   assign own_cnt = cur_ff.source ? cnt_b_ff : cnt_a_ff;
   assign rd_addr = idx_ff[IdxW-1:0];

   always_comb begin
      unique case (state_ff)
         BK_IDLE: state_in = job_valid ? BK_SCAN : BK_IDLE;
         BK_SCAN: state_in = (idx_ff == limit && !rd_ok_ff) ? BK_STORE : BK_SCAN;
         BK_STORE: state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      job_take = (state_ff == BK_IDLE) && job_valid;
      wr_en = (state_ff == BK_STORE) && (own_cnt != CntW'(GroupDepth));
   end

   always_comb begin
      s = cur_ff.source ? rd_a_ff : rd_b_ff;
      hi = ($signed({2'b0, cur_ff.rec.span_end}) < $signed({2'b0, s.span_end})) ?
           $signed({2'b0, cur_ff.rec.span_end}) : $signed({2'b0, s.span_end});
      lo = ($signed({2'b0, cur_ff.rec.span_start}) > $signed({2'b0, s.span_start})) ?
           $signed({2'b0, cur_ff.rec.span_start}) : $signed({2'b0, s.span_start});
      uhi = ($signed({2'b0, cur_ff.rec.span_end}) > $signed({2'b0, s.span_end})) ?
            $signed({2'b0, cur_ff.rec.span_end}) : $signed({2'b0, s.span_end});
      ulo = ($signed({2'b0, cur_ff.rec.span_start}) < $signed({2'b0, s.span_start})) ?
            $signed({2'b0, cur_ff.rec.span_start}) : $signed({2'b0, s.span_start});
      inter = (hi > lo) ? hi - lo : '0;
      uni = uhi - ulo;
      lhs = 21'(uni - inter) * 21'sd5;
      passes = (uni > 0) && (lhs < 21'(uni));
      lq = (cur_ff.rec.query_id < s.query_id) ? cur_ff.rec.query_id : s.query_id;
   end

   always_comb begin
      cur_in = cur_ff;
      cnt_a_in = cnt_a_ff;
      cnt_b_in = cnt_b_ff;
      ovf_in = ovf_ff;
      idx_in = idx_ff;
      rd_ok_in = 1'b0;
      pend_in = pend_ff;
      hold_in = hold_ff;
      rsp_strobe = 1'b0;
      rsp_data = hold_ff;
      if (job_take) begin
         cur_in = job_data;
         idx_in = '0;
         if (job_data.new_key) begin
            cnt_a_in = '0;
            cnt_b_in = '0;
            ovf_in = 1'b0;
         end
      end
      if (state_ff == BK_SCAN && idx_ff != limit) begin
         idx_in = idx_ff + 1'b1;
         rd_ok_in = 1'b1;
      end
      if (rd_ok_ff && passes) begin
         if (pend_ff) begin
            rsp_strobe = 1'b1;
            rsp_data = hold_ff;
         end
         pend_in = 1'b1;
         hold_in.low_query = lq;
         hold_in.high_query = (cur_ff.rec.query_id < s.query_id) ?
                              s.query_id : cur_ff.rec.query_id;
         hold_in.pair_norm = (cur_ff.rec.query_size < s.query_size) ?
                             cur_ff.rec.query_size : s.query_size;
         hold_in.bucket = (lq < split_low) ? 2'd0 : (lq < split_high) ? 2'd1 : 2'd2;
         hold_in.last = 1'b0;
         hold_in.overflowed = ovf_ff;
      end
      if (state_ff == BK_STORE) begin
         if (pend_ff) begin
            rsp_strobe = 1'b1;
            rsp_data = hold_ff;
            rsp_data.last = 1'b1;
            pend_in = 1'b0;
         end
         if (wr_en) begin
            if (cur_ff.source) cnt_b_in = cnt_b_ff + 1'b1;
            else cnt_a_in = cnt_a_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
         ovf_ff <= 1'b0;
         idx_ff <= '0;
         rd_ok_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_a_ff <= cnt_a_in;
         cnt_b_ff <= cnt_b_in;
         ovf_ff <= ovf_in;
         idx_ff <= idx_in;
         rd_ok_ff <= rd_ok_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      hold_ff <= hold_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en && !cur_ff.source) begin
         mem_a[own_cnt[IdxW-1:0]] <= cur_ff.rec;
      end
      rd_a_ff <= mem_a[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en && cur_ff.source) begin
         mem_b[own_cnt[IdxW-1:0]] <= cur_ff.rec;
      end
      rd_b_ff <= mem_b[rd_addr];
   end

endmodule

// ===== hdl/interval_overlap_group_join.sv =====
// Interval-overlap group join. A record is taken when start is high and busy is low; a
// two-word queue lets the front take records while the back scans. The back compares a
// record against the other source's store, one stored entry per cycle through the store's
// read port. Each passing pair is shown for one cycle with rsp_strobe; the receiver
// cannot stall, and a pair is held one compare behind so the final one carries last.
module interval_overlap_group_join (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_start,
   output logic                req_busy,
   input  iogj_pkg::req_type   req_data,
   output logic                rsp_strobe,
   output iogj_pkg::rsp_type   rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import iogj_pkg::*;

   logic [31:0] split_low_ff, split_high_ff;
   logic        job_valid, job_take;
   job_type     job_data;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         split_low_ff <= SplitLowReset;
         split_high_ff <= SplitHighReset;
      end else if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
         if (paddr[2] == RegSplitLow) split_low_ff <= pwdata;
         else split_high_ff <= pwdata;
      end
   end

   always_comb begin
      unique case (paddr[2])
         RegSplitLow: prdata = split_low_ff;
         default:     prdata = split_high_ff;
      endcase
   end

   iogj_front u_front (
      .clock(clock), .reset(reset),
      .req_start(req_start), .req_busy(req_busy), .req_data(req_data),
      .job_valid(job_valid), .job_data(job_data), .job_take(job_take)
   );

   iogj_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(job_valid), .job_data(job_data), .job_take(job_take),
      .split_low(split_low_ff), .split_high(split_high_ff),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

endmodule
